>>> hdl/credential_access_table_check_defines.svh
// assertion macros for the credential access table check
// used by the checker module, no other dependencies
`ifndef CREDENTIAL_ACCESS_TABLE_CHECK_DEFINES_SVH
`define CREDENTIAL_ACCESS_TABLE_CHECK_DEFINES_SVH

// same-cycle implication, off during reset
`define CRD_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define CRD_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/crd_pkg.sv
// shared constants, types and helpers of the credential access table check
// no dependencies
package crd_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int OP_W      = 2;
  localparam int ID_W      = 56;
  localparam int ID_BYTES  = 7;
  localparam int LEN_W     = 3;
  localparam int FLOOR_W   = 32;
  localparam int TIME_W    = 32;
  localparam int MIN_W     = 11;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int GATE_W    = 5;
  localparam int VERDICT_W = 2;
  localparam int COUNT_W   = 9;

  localparam logic [GATE_W-1:0] GATE_FLOOR_RESET = GATE_W'(3);
  localparam logic [MIN_W-1:0]  MINUTES_PER_HOUR = MIN_W'(60);

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [VERDICT_W-1:0] VERDICT_GRANTED  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN  = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_EXPIRED  = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_SCHEDULE = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [FLOOR_W-1:0] floor_bits;
    logic [TIME_W-1:0]  expiry;
    logic [MIN_W-1:0]   win_start;
    logic [MIN_W-1:0]   win_end;
  } entry_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] now_seconds;
    logic [MIN_W-1:0]  minutes;
    logic [GATE_W-1:0] gate;
  } key_t;

  // search token walking down the cell row
  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [VERDICT_W-1:0] verdict;
  } tok_t;

  // keeps the first len bytes of an id
  function automatic logic [ID_W-1:0] id_mask(input logic [LEN_W-1:0] len);
    logic [ID_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < ID_BYTES; b++) begin
      if (LEN_W'(b) < len) begin
        mask[8*b +: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

endpackage

>>> hdl/crd_ifs.sv
// valid/ready channel interfaces: input items, results and register writes
// depends on crd_pkg
interface crd_in_if;
  import crd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [ID_W-1:0]       card_id;
  logic [LEN_W-1:0]      card_id_length;
  logic [FLOOR_W-1:0]    floor_bits;
  logic [TIME_W-1:0]     expiry_time;
  logic [MIN_W-1:0]      window_start;
  logic [MIN_W-1:0]      window_end;
  logic [TIME_W-1:0]     now_seconds;
  logic [HOUR_W-1:0]     now_hour;
  logic [MINUTE_W-1:0]   now_minute;

  modport source (output valid, operation, card_id, card_id_length, floor_bits,
                  expiry_time, window_start, window_end, now_seconds, now_hour,
                  now_minute, input ready);
  modport sink (input valid, operation, card_id, card_id_length, floor_bits,
                expiry_time, window_start, window_end, now_seconds, now_hour,
                now_minute, output ready);
endinterface

interface crd_out_if;
  import crd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic                 table_full;
  logic [COUNT_W-1:0]   entry_count;

  modport source (output valid, verdict, table_full, entry_count, input ready);
  modport sink (input valid, verdict, table_full, entry_count, output ready);
endinterface

interface crd_cfg_if;
  import crd_pkg::*;
  logic              valid;
  logic              ready;
  logic [GATE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> hdl/crd_cell.sv
// one table cell: holds one credential entry and passes the search token on
// depends on crd_pkg
module crd_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [crd_pkg::IDX_W-1:0] cell_index,
  input  logic [crd_pkg::CNT_W-1:0] held,
  input  logic                  wr_en,
  input  logic [crd_pkg::IDX_W-1:0] wr_idx,
  input  crd_pkg::entry_t       wr_entry,
  input  crd_pkg::key_t         key,
  input  crd_pkg::tok_t         tok_in,
  output crd_pkg::tok_t         tok_out
);
  import crd_pkg::*;

  entry_t               entry;
  logic                 in_use;
  logic                 hit;
  logic [VERDICT_W-1:0] verdict;
  tok_t                 tok_next;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == cell_index)) begin
      entry <= wr_entry;
    end
  end

  always_comb begin
    in_use = (CNT_W'(cell_index) < held);
    hit    = in_use && (entry.len == key.len) && (entry.id == key.id);
    priority if (key.now_seconds > entry.expiry) begin
      verdict = VERDICT_EXPIRED;
    end else if (!entry.floor_bits[key.gate]) begin
      verdict = VERDICT_UNKNOWN;
    end else if ((key.minutes < entry.win_start) || (key.minutes >= entry.win_end)) begin
      verdict = VERDICT_SCHEDULE;
    end else begin
      verdict = VERDICT_GRANTED;
    end
    tok_next = tok_in;
    if (tok_in.valid && !tok_in.found && hit) begin
      tok_next.found   = 1'b1;
      tok_next.verdict = verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

>>> hdl/credential_access_table_check.sv
// top level of the credential access table check: control, count and cell row
// depends on crd_pkg, crd_ifs and crd_cell
//
// A table of up to TABLE_DEPTH credential entries held in a row of cells, one
// entry per cell. A clear or append beat places its result in the holding
// register, from which it moves to the output register. A lookup beat sends a
// search token down the row, one cell per clock; no new item is accepted until
// the token has left the last cell and its result the holding register.
// The scanned key and the time of day are broadcast to all cells; the first
// in-use cell whose id and length match marks the token and fills in the
// verdict, later cells leave it alone. A result sits in a holding register and
// an output register, so a new item is taken while an earlier result waits in
// the output register. The gate floor register is written through the cfg
// channel, which is always ready. Table storage has no reset: only cells below
// the held count take part in a lookup.
module credential_access_table_check (
  input  logic      clk,
  input  logic      rst,
  crd_in_if.sink    item,
  crd_out_if.source result,
  crd_cfg_if.sink   cfg
);
  import crd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic              state;
  logic [CNT_W-1:0]  count;
  logic [GATE_W-1:0] gate_floor;
  logic              start_tok;
  key_t              key;

  // holding stage behind the control
  logic                 pend_valid;
  logic [VERDICT_W-1:0] pend_verdict;
  logic                 pend_full;
  logic [CNT_W-1:0]     pend_count;

  // output register
  logic                 res_valid;
  logic [VERDICT_W-1:0] res_verdict;
  logic                 res_full;
  logic [CNT_W-1:0]     res_count;

  logic              accept;
  logic              is_full;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  entry_t            wr_entry;
  logic [ID_W-1:0]   masked_id;
  logic              move_out;

  tok_t tok [TABLE_DEPTH+1];

  assign item.ready = (state == ST_IDLE) && !pend_valid;
  assign cfg.ready  = 1'b1;
  assign accept     = item.valid && item.ready;
  assign is_full    = (count >= CNT_W'(TABLE_DEPTH));
  assign move_out   = !res_valid || result.ready;

  // bytes above the id length never take part
  assign masked_id = item.card_id & id_mask(item.card_id_length);

  // append write goes straight into the cell at the current count
  assign wr_en  = accept && (item.operation == OP_APPEND) && !is_full;
  assign wr_idx = IDX_W'(count);

  always_comb begin
    wr_entry.id         = masked_id;
    wr_entry.len        = item.card_id_length;
    wr_entry.floor_bits = item.floor_bits;
    wr_entry.expiry     = item.expiry_time;
    wr_entry.win_start  = item.window_start;
    wr_entry.win_end    = item.window_end;
  end

  // lookup key, held steady for the whole scan
  always_ff @(posedge clk) begin
    if (accept) begin
      key.id          <= masked_id;
      key.len         <= item.card_id_length;
      key.now_seconds <= item.now_seconds;
      key.minutes     <= MIN_W'(item.now_hour) * MINUTES_PER_HOUR + MIN_W'(item.now_minute);
      key.gate        <= gate_floor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      gate_floor   <= GATE_FLOOR_RESET;
      start_tok    <= 1'b0;
      pend_valid   <= 1'b0;
      pend_verdict <= VERDICT_GRANTED;
      pend_full    <= 1'b0;
      pend_count   <= '0;
      res_valid    <= 1'b0;
      res_verdict  <= VERDICT_GRANTED;
      res_full     <= 1'b0;
      res_count    <= '0;
    end else begin
      // token enters the row in the cycle after a lookup beat
      start_tok <= accept && (item.operation == OP_LOOKUP);

      if (cfg.valid && cfg.ready) begin
        gate_floor <= cfg.data;
      end

      // holding stage to output register
      if (move_out) begin
        res_valid   <= pend_valid;
        res_verdict <= pend_verdict;
        res_full    <= pend_full;
        res_count   <= pend_count;
      end
      if (move_out && pend_valid) begin
        pend_valid <= 1'b0;
      end

      if (accept) begin
        unique case (item.operation)
          OP_CLEAR: begin
            count        <= '0;
            pend_valid   <= 1'b1;
            pend_verdict <= VERDICT_GRANTED;
            pend_full    <= 1'b0;
            pend_count   <= '0;
          end
          OP_APPEND: begin
            pend_valid   <= 1'b1;
            pend_verdict <= VERDICT_GRANTED;
            if (is_full) begin
              pend_full  <= 1'b1;
              pend_count <= count;
            end else begin
              count      <= count + CNT_W'(1);
              pend_full  <= 1'b0;
              pend_count <= count + CNT_W'(1);
            end
          end
          OP_LOOKUP: begin
            state <= ST_SCAN;
          end
          default: begin
            // unused code: no effect, report the count
            pend_valid   <= 1'b1;
            pend_verdict <= VERDICT_GRANTED;
            pend_full    <= 1'b0;
            pend_count   <= count;
          end
        endcase
      end

      // token left the last cell
      if ((state == ST_SCAN) && tok[TABLE_DEPTH].valid) begin
        state        <= ST_IDLE;
        pend_valid   <= 1'b1;
        pend_verdict <= tok[TABLE_DEPTH].found ? tok[TABLE_DEPTH].verdict : VERDICT_UNKNOWN;
        pend_full    <= 1'b0;
        pend_count   <= count;
      end
    end
  end

  always_comb begin
    tok[0].valid   = start_tok;
    tok[0].found   = 1'b0;
    tok[0].verdict = VERDICT_UNKNOWN;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    crd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_index (IDX_W'(i)),
      .held       (count),
      .wr_en      (wr_en),
      .wr_idx     (wr_idx),
      .wr_entry   (wr_entry),
      .key        (key),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );
  end

  assign result.valid       = res_valid;
  assign result.verdict     = res_verdict;
  assign result.table_full  = res_full;
  assign result.entry_count = COUNT_W'(res_count);

endmodule

>>> hdl/crd_checker.sv
// port-level checks of the credential access table check, bound to the top
// depends on crd_pkg and the assertion macro header
`include "credential_access_table_check_defines.svh"

module crd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [crd_pkg::VERDICT_W-1:0] res_verdict,
  input logic                         res_full,
  input logic [crd_pkg::COUNT_W-1:0]  res_count
);
  import crd_pkg::*;

  `CRD_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_verdict) && $stable(res_full) && $stable(res_count), "result beat changed while stalled")
  `CRD_ASSERT_NOW(a_count_max, clk, rst, res_valid, res_count <= COUNT_W'(TABLE_DEPTH), "entry count above table depth")
  `CRD_ASSERT_NOW(a_full_count, clk, rst, res_valid && res_full, res_count == COUNT_W'(TABLE_DEPTH) && res_verdict == VERDICT_GRANTED, "dropped append without a full table")
  `CRD_ASSERT_NEXT(a_one_item, clk, rst, item_valid && item_ready, !item_ready, "second item taken right after the first")

endmodule

bind credential_access_table_check crd_checker u_crd_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_verdict (result.verdict),
  .res_full    (result.table_full),
  .res_count   (result.entry_count)
);
